### rtl/sida_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sida_pkg;

  localparam int MAX_SLOTS  = 2048;
  localparam int SLOT_W     = 11;
  localparam int CFG_W      = 12;
  localparam int HW_W       = 12;
  localparam int RID_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int MAP_WORD_W = 32;
  localparam int MAP_WORDS  = MAX_SLOTS / MAP_WORD_W;
  localparam int WIDX_W     = 6;
  localparam int BIDX_W     = 5;

  localparam logic [RID_W-1:0] SENTINEL_ID = 16'hffff;
  localparam logic [CFG_W-1:0] MAX_SLOTS_RESET = 12'd2048;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_RELEASED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_SENTINEL  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd5;

  // Result of the shared 8-bit leading-one encoder
  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } penc_res_t;

endpackage
`default_nettype wire

### rtl/sida_prienc8.sv
`timescale 1ns / 1ps
`default_nettype none
module sida_prienc8 (
  input  wire logic [7:0]          vec,
  output sida_pkg::penc_res_t      res
);
  import sida_pkg::*;

  // Pick the highest set bit; later iterations override lower ones
  always_comb begin
    res.found = |vec;
    res.idx   = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (vec[i]) begin
        res.idx = 3'(i);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/slot_id_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Slot identifier allocator. An item is taken when start is high and busy is low;
// exactly one result follows as a one-cycle out_valid pulse that cannot be held
// off, so the receiver must take it when it appears. Allocation from the free
// set steps through DEC, WSEL, RD, EVAL, BIT and WR before the result strobe; a
// fresh or exhausted allocation, a sentinel or an out-of-range release ends in DEC,
// a release walks DEC, RD, EVAL and WR, one of an identifier already free ends in
// EVAL. The sequencer walks one shared 8-bit leading-one encoder over a 64-bit
// word summary and then over one 32-bit word of the free bitmap, with one
// registered read of the bitmap memory in between. No clearing pass after reset:
// per-word valid flops make unwritten bitmap words read as empty.
module slot_id_allocator_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire logic                           in_mode,
  input  wire logic [sida_pkg::RID_W-1:0]     in_release_id,
  output      logic                           out_valid,
  output      logic [sida_pkg::STATUS_W-1:0]  out_status,
  output      logic [sida_pkg::SLOT_W-1:0]    out_slot_id,
  input  wire logic                           cfg_we,
  input  wire logic [sida_pkg::CFG_W-1:0]     cfg_wdata
);
  import sida_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_WSEL = 7'b0000100,
    S_RD   = 7'b0001000,
    S_EVAL = 7'b0010000,
    S_BIT  = 7'b0100000,
    S_WR   = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CFG_W-1:0]       max_slots_r;
  logic [HW_W-1:0]        hw_r, hw_nxt;
  logic                   mode_r;
  logic [RID_W-1:0]       rid_r;
  logic [2:0]             grp_r, grp_nxt;
  logic [WIDX_W-1:0]      widx_r, widx_nxt;
  logic [1:0]             byte_r, byte_nxt;
  logic [BIDX_W-1:0]      bidx_r, bidx_nxt;
  logic [MAP_WORD_W-1:0]  wnew_r, wnew_nxt;
  logic [MAP_WORDS-1:0]   summary_r;
  logic [MAP_WORDS-1:0]   wvalid_r;
  logic [MAP_WORD_W-1:0]  mem [MAP_WORDS];
  logic [MAP_WORD_W-1:0]  rd_data_r;
  logic                   rd_valid_r;
  logic [MAP_WORD_W-1:0]  word;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic [HW_W-1:0]        limit;
  logic [7:0]             grp_any;
  logic [7:0]             byte_any;
  logic [7:0]             pe_vec;
  penc_res_t              pe;
  logic                   accept;

  assign busy        = (state_r != S_IDLE);
  assign accept      = start && !busy;
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_slot_id = out_slot_r;

  // Saturate the configured limit to the table size
  assign limit = (max_slots_r > CFG_W'(MAX_SLOTS)) ? HW_W'(MAX_SLOTS) : max_slots_r;

  // Unwritten bitmap words read as empty
  assign word = rd_valid_r ? rd_data_r : '0;

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_any[g] = |summary_r[g*8 +: 8];
    end
    byte_any = {4'b0000, |word[31:24], |word[23:16], |word[15:8], |word[7:0]};
  end

  // Feed the shared encoder according to the step in progress
  always_comb begin
    unique case (state_r)
      S_DEC:   pe_vec = grp_any;
      S_WSEL:  pe_vec = summary_r[grp_r*8 +: 8];
      S_EVAL:  pe_vec = byte_any;
      S_BIT:   pe_vec = word[byte_r*8 +: 8];
      default: pe_vec = 8'h00;
    endcase
  end

  sida_prienc8 u_penc (
    .vec (pe_vec),
    .res (pe)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    hw_nxt         = hw_r;
    grp_nxt        = grp_r;
    widx_nxt       = widx_r;
    byte_nxt       = byte_r;
    bidx_nxt       = bidx_r;
    wnew_nxt       = wnew_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (mode_r) begin
          if (rid_r == SENTINEL_ID) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_SENTINEL;
            out_slot_nxt   = '0;
            state_nxt      = S_IDLE;
          end else if (rid_r >= RID_W'(hw_r) || rid_r >= RID_W'(MAX_SLOTS)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_RANGE;
            out_slot_nxt   = '0;
            state_nxt      = S_IDLE;
          end else begin
            widx_nxt  = rid_r[SLOT_W-1:BIDX_W];
            bidx_nxt  = rid_r[BIDX_W-1:0];
            state_nxt = S_RD;
          end
        end else if (pe.found) begin
          grp_nxt   = pe.idx;
          state_nxt = S_WSEL;
        end else if (hw_r >= limit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_EXHAUSTED;
          out_slot_nxt   = '0;
          state_nxt      = S_IDLE;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_ALLOCATED;
          out_slot_nxt   = hw_r[SLOT_W-1:0];
          hw_nxt         = hw_r + HW_W'(1);
          state_nxt      = S_IDLE;
        end
      end
      S_WSEL: begin
        widx_nxt  = {grp_r, pe.idx};
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (mode_r) begin
          if (word[bidx_r]) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_DUPLICATE;
            out_slot_nxt   = '0;
            state_nxt      = S_IDLE;
          end else begin
            wnew_nxt  = word | (MAP_WORD_W'(1) << bidx_r);
            state_nxt = S_WR;
          end
        end else begin
          byte_nxt  = pe.idx[1:0];
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        bidx_nxt  = {byte_r, pe.idx};
        wnew_nxt  = word & ~(MAP_WORD_W'(1) << {byte_r, pe.idx});
        state_nxt = S_WR;
      end
      S_WR: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = mode_r ? STAT_RELEASED : STAT_ALLOCATED;
        out_slot_nxt   = mode_r ? '0 : {widx_r, bidx_r};
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_slots_r <= MAX_SLOTS_RESET;
      hw_r        <= '0;
      summary_r   <= '0;
      wvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_slots_r <= cfg_wdata;
      end
      if (state_r == S_WR) begin
        summary_r[widx_r] <= |wnew_r;
        wvalid_r[widx_r]  <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      rid_r  <= in_release_id;
    end
    grp_r        <= grp_nxt;
    widx_r       <= widx_nxt;
    byte_r       <= byte_nxt;
    bidx_r       <= bidx_nxt;
    wnew_r       <= wnew_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // Free bitmap memory: one registered read, one write port
  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      rd_data_r  <= mem[widx_r];
      rd_valid_r <= wvalid_r[widx_r];
    end
    if (state_r == S_WR) begin
      mem[widx_r] <= wnew_r;
    end
  end

  // Checks
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_ALLOCATED) |-> (out_slot_id == '0))
    else $error("non-allocation result carries a slot id");

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= HW_W'(MAX_SLOTS))
    else $error("high-water mark beyond table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not make the block busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("item finished without a result strobe");

endmodule
`default_nettype wire
